[hw/rtl/ptba_pkg.sv]
// Shared constants and types for the point to binary angle block.
package ptba_pkg;

    // Slope index range and table geometry
    localparam int SLOPE_RANGE = 2048;
    localparam int TABLE_DEPTH = SLOPE_RANGE + 1;
    localparam int TBL_AW      = $clog2(TABLE_DEPTH);
    localparam int QUO_W       = $clog2(SLOPE_RANGE) + 1;

    // Fixed field widths
    localparam int COORD_W     = 32;
    localparam int ANGLE_W     = 32;
    localparam int CMD_W       = 2;
    localparam int ENTRY_IDX_W = 12;
    localparam int CFG_IDX_W   = 1;

    // Divider geometry: dividend is num << 3, divisor is den >> 8
    localparam int NUM_SHIFT   = 3;
    localparam int DEN_SHIFT   = 8;
    localparam int DIV_W       = COORD_W - DEN_SHIFT;
    localparam int TRIAL_W     = DIV_W + QUO_W;
    localparam logic [COORD_W-1:0] DEN_MIN = COORD_W'(512);

    // Octant offsets
    localparam logic [ANGLE_W-1:0] ANG_Q90  = 32'h4000_0000;
    localparam logic [ANGLE_W-1:0] ANG_Q180 = 32'h8000_0000;
    localparam logic [ANGLE_W-1:0] ANG_Q270 = 32'hC000_0000;

    // Commands
    localparam logic [CMD_W-1:0] CMD_VIEW   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_POINTS = 2'd1;
    localparam logic [CMD_W-1:0] CMD_LOAD   = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_VIEW_ORIGIN_X = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_VIEW_ORIGIN_Y = 1'd1;

    // Control that travels with each item down the pipeline
    typedef struct packed {
        logic                valid;
        logic                load;
        logic                zero;
        logic                sub_off;
        logic [ANGLE_W-1:0]  base;
        logic [TBL_AW-1:0]   wr_addr;
        logic [ANGLE_W-1:0]  wr_data;
    } pipe_ctl_t;

endpackage

[hw/rtl/point_to_binary_angle.sv]
// Top level: pipelined vector to binary angle converter with arctangent table.
//
//  channel  | handshake          | payload
//  ---------+--------------------+------------------------------------------------
//  command  | start / busy       | cmd, from_x, from_y, to_x, to_y,
//           |                    | entry_index, entry_value
//  result   | done (one cycle)   | angle
//  config   | cfg_we             | cfg_addr, cfg_wdata
//
//  One item enters per cycle; busy stays low. An angle item passes in order through
//  the difference, magnitude and fold stages, the divider setup stage, the stages of
//  the pipelined divider that each resolve a quotient bit, a table read and an
//  offset add.
//  Load items write the table in order with the angle items around them.
//  Reset clears the valid bits and the view origin; the table holds no reset.
module point_to_binary_angle
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic [ptba_pkg::CMD_W-1:0]         cmd,
    input  logic signed [ptba_pkg::COORD_W-1:0] from_x,
    input  logic signed [ptba_pkg::COORD_W-1:0] from_y,
    input  logic signed [ptba_pkg::COORD_W-1:0] to_x,
    input  logic signed [ptba_pkg::COORD_W-1:0] to_y,
    input  logic [ptba_pkg::ENTRY_IDX_W-1:0]   entry_index,
    input  logic [ptba_pkg::ANGLE_W-1:0]       entry_value,
    output logic                               done,
    output logic [ptba_pkg::ANGLE_W-1:0]       angle,
    input  logic                               cfg_we,
    input  logic [ptba_pkg::CFG_IDX_W-1:0]     cfg_addr,
    input  logic [ptba_pkg::COORD_W-1:0]       cfg_wdata
);
    import ptba_pkg::*;

    // Configuration registers
    logic [COORD_W-1:0] view_x_reg;
    logic [COORD_W-1:0] view_y_reg;

    // Stage A: differences
    pipe_ctl_t          a_ctl_reg, a_ctl_next;
    logic [COORD_W-1:0] a_dx_reg, a_dx_next;
    logic [COORD_W-1:0] a_dy_reg, a_dy_next;

    // Stage B: magnitudes and signs
    pipe_ctl_t          b_ctl_reg, b_ctl_next;
    logic [COORD_W-1:0] b_ax_reg, b_ax_next;
    logic [COORD_W-1:0] b_ay_reg, b_ay_next;
    logic               b_xneg_reg, b_xneg_next;
    logic               b_yneg_reg, b_yneg_next;

    // Stage C: octant fold
    pipe_ctl_t          c_ctl_reg, c_ctl_next;
    logic [COORD_W-1:0] c_num_reg, c_num_next;
    logic [COORD_W-1:0] c_den_reg, c_den_next;

    // Divider pipeline, entry 0 is the setup stage
    pipe_ctl_t          dv_ctl_reg [0:QUO_W];
    logic [COORD_W-1:0] dv_rem_reg [0:QUO_W];
    logic [DIV_W-1:0]   dv_div_reg [0:QUO_W];
    logic [QUO_W-1:0]   dv_quo_reg [0:QUO_W];
    logic               dv_sat_reg [0:QUO_W];
    pipe_ctl_t          dv0_ctl_next;
    logic [COORD_W-1:0] dv0_rem_next;
    logic [DIV_W-1:0]   dv0_div_next;
    logic               dv0_sat_next;

    // Table read stage
    logic [ANGLE_W-1:0] atan_mem [0:TABLE_DEPTH-1];
    logic [TBL_AW-1:0]  rd_addr;
    logic [ANGLE_W-1:0] rd_data_reg;
    pipe_ctl_t          m_ctl_reg;

    // Output stage
    logic [ANGLE_W-1:0] angle_reg, angle_next;
    logic               done_reg;

    assign busy  = 1'b0;
    assign done  = done_reg;
    assign angle = angle_reg;

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            view_x_reg <= '0;
            view_y_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                REG_VIEW_ORIGIN_X: view_x_reg <= cfg_wdata;
                REG_VIEW_ORIGIN_Y: view_y_reg <= cfg_wdata;
                default:           ;
            endcase
        end
    end

    // Stage A: pick the origin, take differences, drop unused or bad items
    always_comb
    begin
        logic [COORD_W-1:0] ox;
        logic [COORD_W-1:0] oy;
        ox = (cmd == CMD_VIEW) ? view_x_reg : from_x;
        oy = (cmd == CMD_VIEW) ? view_y_reg : from_y;
        a_dx_next = to_x - ox;
        a_dy_next = to_y - oy;
        a_ctl_next         = '0;
        a_ctl_next.wr_addr = TBL_AW'(entry_index);
        a_ctl_next.wr_data = entry_value;
        case (cmd)
            CMD_VIEW, CMD_POINTS:
            begin
                a_ctl_next.valid = start;
            end
            CMD_LOAD:
            begin
                a_ctl_next.valid = start
                    && (32'(entry_index) <= 32'(SLOPE_RANGE));
                a_ctl_next.load  = 1'b1;
            end
            default:
            begin
                a_ctl_next.valid = 1'b0;
            end
        endcase
    end

    // Stage B: wrap-negate negative differences, flag the zero vector
    always_comb
    begin
        b_ctl_next      = a_ctl_reg;
        b_ctl_next.zero = (a_dx_reg == '0) && (a_dy_reg == '0);
        b_xneg_next     = a_dx_reg[COORD_W-1];
        b_yneg_next     = a_dy_reg[COORD_W-1];
        b_ax_next       = b_xneg_next ? (COORD_W'(0) - a_dx_reg) : a_dx_reg;
        b_ay_next       = b_yneg_next ? (COORD_W'(0) - a_dy_reg) : a_dy_reg;
    end

    // Stage C: signed compare, choose numerator, denominator and offset
    always_comb
    begin
        logic gt;
        gt = $signed(b_ax_reg) > $signed(b_ay_reg);
        c_ctl_next = b_ctl_reg;
        c_num_next = gt ? b_ay_reg : b_ax_reg;
        c_den_next = gt ? b_ax_reg : b_ay_reg;
        case ({b_xneg_reg, b_yneg_reg})
            2'b00:
            begin
                c_ctl_next.base    = gt ? '0 : (ANG_Q90 - 1'b1);
                c_ctl_next.sub_off = !gt;
            end
            2'b01:
            begin
                c_ctl_next.base    = gt ? '0 : ANG_Q270;
                c_ctl_next.sub_off = gt;
            end
            2'b10:
            begin
                c_ctl_next.base    = gt ? (ANG_Q180 - 1'b1) : ANG_Q90;
                c_ctl_next.sub_off = gt;
            end
            default:
            begin
                c_ctl_next.base    = gt ? ANG_Q180 : (ANG_Q270 - 1'b1);
                c_ctl_next.sub_off = !gt;
            end
        endcase
    end

    // Divider setup: scale operands, flag a saturated slope
    always_comb
    begin
        logic [TRIAL_W-1:0] top;
        dv0_ctl_next = c_ctl_reg;
        dv0_rem_next = c_num_reg << NUM_SHIFT;
        dv0_div_next = c_den_reg[COORD_W-1:DEN_SHIFT];
        top          = TRIAL_W'(dv0_div_next) << QUO_W;
        dv0_sat_next = (c_den_reg < DEN_MIN) || (TRIAL_W'(dv0_rem_next) >= top);
    end

    // Front stages
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_ctl_reg     <= '0;
            b_ctl_reg     <= '0;
            c_ctl_reg     <= '0;
            dv_ctl_reg[0] <= '0;
        end
        else
        begin
            a_ctl_reg     <= a_ctl_next;
            b_ctl_reg     <= b_ctl_next;
            c_ctl_reg     <= c_ctl_next;
            dv_ctl_reg[0] <= dv0_ctl_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_dx_reg      <= a_dx_next;
        a_dy_reg      <= a_dy_next;
        b_ax_reg      <= b_ax_next;
        b_ay_reg      <= b_ay_next;
        b_xneg_reg    <= b_xneg_next;
        b_yneg_reg    <= b_yneg_next;
        c_num_reg     <= c_num_next;
        c_den_reg     <= c_den_next;
        dv_rem_reg[0] <= dv0_rem_next;
        dv_div_reg[0] <= dv0_div_next;
        dv_quo_reg[0] <= '0;
        dv_sat_reg[0] <= dv0_sat_next;
    end

    // Restoring divider: one quotient bit per stage, most significant first
    for (genvar j = 0; j < QUO_W; j++)
    begin : g_div
        localparam int K = QUO_W - 1 - j;
        logic [TRIAL_W-1:0] trial;
        logic               ge;
        logic [COORD_W-1:0] rem_next;
        logic [QUO_W-1:0]   quo_next;

        assign trial    = TRIAL_W'(dv_div_reg[j]) << K;
        assign ge       = TRIAL_W'(dv_rem_reg[j]) >= trial;
        assign rem_next = ge ? (dv_rem_reg[j] - trial[COORD_W-1:0]) : dv_rem_reg[j];
        assign quo_next = dv_quo_reg[j] | (QUO_W'(ge) << K);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                dv_ctl_reg[j+1] <= '0;
            end
            else
            begin
                dv_ctl_reg[j+1] <= dv_ctl_reg[j];
            end
        end

        always_ff @(posedge clk)
        begin
            dv_rem_reg[j+1] <= rem_next;
            dv_div_reg[j+1] <= dv_div_reg[j];
            dv_quo_reg[j+1] <= quo_next;
            dv_sat_reg[j+1] <= dv_sat_reg[j];
        end
    end

    // Clamp the quotient into the table range
    always_comb
    begin
        if (dv_sat_reg[QUO_W] || (dv_quo_reg[QUO_W] > QUO_W'(SLOPE_RANGE)))
        begin
            rd_addr = TBL_AW'(SLOPE_RANGE);
        end
        else
        begin
            rd_addr = TBL_AW'(dv_quo_reg[QUO_W]);
        end
    end

    // Table: load items write, angle items read, in pipeline order
    always_ff @(posedge clk)
    begin
        if (dv_ctl_reg[QUO_W].valid && dv_ctl_reg[QUO_W].load)
        begin
            atan_mem[dv_ctl_reg[QUO_W].wr_addr] <= dv_ctl_reg[QUO_W].wr_data;
        end
        rd_data_reg <= atan_mem[rd_addr];
    end

    // Apply the octant offset
    always_comb
    begin
        if (m_ctl_reg.zero)
        begin
            angle_next = '0;
        end
        else if (m_ctl_reg.sub_off)
        begin
            angle_next = m_ctl_reg.base - rd_data_reg;
        end
        else
        begin
            angle_next = m_ctl_reg.base + rd_data_reg;
        end
    end

    // Table and output stages
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_ctl_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            m_ctl_reg <= dv_ctl_reg[QUO_W];
            done_reg  <= m_ctl_reg.valid && !m_ctl_reg.load;
        end
    end

    always_ff @(posedge clk)
    begin
        angle_reg <= angle_next;
    end

endmodule
